// File: hdl/pwm_compare_timer_top_macros.svh
// ---------------------------------------------------------------------------
// PWM compare timer assertion macros
// Shared assertion wrappers for the timer's checker.
// ---------------------------------------------------------------------------
`ifndef PWM_COMPARE_TIMER_TOP_MACROS_SVH
`define PWM_COMPARE_TIMER_TOP_MACROS_SVH

// Same-cycle implication, reset-qualified.
`define PCT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, reset-qualified.
`define PCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/pct_pkg.sv
// ---------------------------------------------------------------------------
// PWM compare timer package
// Types, register offsets and field layout shared by the timer modules.
// ---------------------------------------------------------------------------
`default_nettype none

package pct_pkg;

	localparam int unsigned NUM_CHANNELS_DEF = 3;
	localparam int unsigned NUM_FLAGS        = 3;   // channels with flag and enable bits
	localparam int unsigned NUM_PINS         = 6;

	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 24;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2
	} req_kind_t;

	// Clock select codes in TCR[1:0]
	localparam logic [1:0] CLK_STOP  = 2'd0;
	localparam logic [1:0] CLK_DIV2  = 2'd1;
	localparam logic [1:0] CLK_DIV8  = 2'd2;

	// Register offsets
	localparam logic [3:0] OFF_TCR   = 4'd0;
	localparam logic [3:0] OFF_TMSR  = 4'd1;
	localparam logic [3:0] OFF_ODL   = 4'd2;
	localparam logic [3:0] OFF_ODR0  = 4'd3;
	localparam logic [3:0] OFF_OCR0H = 4'd6;
	localparam logic [3:0] OFF_OCR0L = 4'd7;
	localparam logic [3:0] OFF_TMRH  = 4'd12;
	localparam logic [3:0] OFF_TMRL  = 4'd13;

	// Control and status bits
	localparam int unsigned TCR_FRM_BIT   = 3;
	localparam int unsigned TCR_OMS_BIT   = 4;
	localparam int unsigned TMSR_TRE0_BIT = 6;
	localparam int unsigned TMSR_TRE2_BIT = 7;

	localparam logic [15:0] CMP_RESET   = 16'hFFFF;
	localparam logic [7:0]  UNDECODED   = 8'hFF;
	localparam logic [1:0]  PAD_ONES    = 2'b11;

	typedef struct packed {
		req_kind_t   req_type;
		logic [3:0]  reg_offset;
		logic [7:0]  write_data;
	} pct_req_t;

	typedef struct packed {
		logic [1:0]  trigger_pulses;
		logic [2:0]  irq_lines;
		logic [5:0]  pin_levels;
		logic [7:0]  read_data;
	} pct_res_t;

	// Last prescaler value before wrap for a running clock select
	function automatic logic [4:0] presc_last(input logic [1:0] sel);
		logic [4:0] last;
		unique case (sel)
			CLK_DIV2: last = 5'd1;
			CLK_DIV8: last = 5'd7;
			default:  last = 5'd31;
		endcase
		return last;
	endfunction

endpackage

`default_nettype wire

// File: hdl/pwm_compare_timer_top.sv
// ---------------------------------------------------------------------------
// PWM compare timer
// Three-channel 16-bit output-compare timer on a stream interface.
// ---------------------------------------------------------------------------
// Each input transaction is one request: a base clock tick, a byte read or a
// byte write at a register offset (kind in tuser). Every request yields
// exactly one result transaction carrying the read byte (zero unless a read),
// the six output pins, the interrupt lines and the trigger pulses as they
// stand after the request. The block takes one transaction per clock while
// the output is not stalled. A request is held in the request register;
// when the output register is free or draining, the timer state is updated
// in a single pass and the result is loaded into the output register,
// where it is presented until taken. A stalled output stalls the request
// register, and the input keeps accepting while that register is free.
// ---------------------------------------------------------------------------
`default_nettype none

module pwm_compare_timer_top import pct_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // reg_offset[3:0], write_data[11:4]
	input  wire logic [1:0]             s_axis_tuser,   // req_type[1:0]
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0]      m_axis_tdata    // read_data[7:0], pin_levels[13:8],
	                                                    // irq_lines[16:14], trigger_pulses[18:17]
);

	logic     req_valid_s1;
	pct_req_t req_s1;
	logic     out_valid_q;
	pct_res_t out_res_q;
	pct_res_t core_res;
	logic     advance;
	logic     step;

	// the request stage moves on whenever the output register is free or draining
	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !req_valid_s1 || advance;
	assign step          = req_valid_s1 && advance;

	// hold the incoming transaction in the request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			req_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.req_type   <= req_kind_t'(s_axis_tuser);
			req_s1.reg_offset <= s_axis_tdata[3:0];
			req_s1.write_data <= s_axis_tdata[11:4];
		end
	end

	pct_core #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.req    (req_s1),
		.res    (core_res)
	);

	// output register: load on a step, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= req_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_res_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(pct_res_t)){1'b0}}, out_res_q};

endmodule

`default_nettype wire

// File: hdl/pct_core.sv
// ---------------------------------------------------------------------------
// PWM compare timer core
// Timer state and the single-pass update for one request.
// ---------------------------------------------------------------------------
`default_nettype none

module pct_core import pct_pkg::*; #(
	parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire pct_req_t req,
	output pct_res_t      res
);

	logic [7:0]  ctrl_q, ctrl_d;
	logic [7:0]  status_q, status_d;
	logic [5:0]  latch_q, latch_d;
	logic [5:0]  odata_q [NUM_CHANNELS];
	logic [5:0]  odata_d [NUM_CHANNELS];
	logic [15:0] cmp_q [NUM_CHANNELS];
	logic [15:0] cmp_d [NUM_CHANNELS];
	logic [15:0] count_q, count_d;
	logic [7:0]  blatch_q, blatch_d;
	logic [2:0]  seen_q, seen_d;
	logic [4:0]  presc_q, presc_d;

	logic                    wrap;
	logic [NUM_CHANNELS-1:0] hit;
	logic [7:0]              rd;
	logic [1:0]              trig;
	logic [2:0]              irq;

	// prescaler wrap on a tick with the clock running
	always_comb begin
		wrap = (req.req_type == REQ_TICK) && (ctrl_q[1:0] != CLK_STOP)
			&& (presc_q == presc_last(ctrl_q[1:0]));
		for (int j = 0; j < NUM_CHANNELS; j++) begin
			hit[j] = wrap && (cmp_q[j] == count_q);
		end
	end

	always_comb begin
		ctrl_d   = ctrl_q;
		status_d = status_q;
		latch_d  = latch_q;
		odata_d  = odata_q;
		cmp_d    = cmp_q;
		count_d  = count_q;
		blatch_d = blatch_q;
		seen_d   = seen_q;
		presc_d  = presc_q;
		rd       = '0;
		trig     = '0;

		unique case (req.req_type)
			REQ_TICK: begin
				if (ctrl_q[1:0] == CLK_STOP) begin
					presc_d = '0;
				end else if (!wrap) begin
					presc_d = presc_q + 5'd1;
				end else begin
					presc_d = '0;
					count_d = count_q + 16'd1;
					if (hit[0] && ctrl_q[TCR_FRM_BIT]) begin
						count_d = '0;
					end
					if (ctrl_q[TCR_OMS_BIT]) begin
						// lowest matching channel wins
						for (int j = NUM_CHANNELS - 1; j >= 0; j--) begin
							if (hit[j]) begin
								latch_d = odata_q[j];
							end
						end
					end else begin
						for (int j = 0; j < NUM_CHANNELS; j++) begin
							if (hit[j]) begin
								latch_d[j] = odata_q[j][j];
							end
						end
					end
					for (int j = 0; j < NUM_CHANNELS && j < NUM_FLAGS; j++) begin
						if (hit[j]) begin
							status_d[j] = 1'b1;
						end
					end
					trig[0] = hit[0] && status_q[TMSR_TRE0_BIT];
					if (NUM_CHANNELS > 2) begin
						trig[1] = hit[NUM_CHANNELS > 2 ? 2 : 0] && status_q[TMSR_TRE2_BIT];
					end
				end
			end
			REQ_READ: begin
				unique case (req.reg_offset)
					OFF_TCR:  rd = ctrl_q;
					OFF_TMSR: begin
						rd     = status_q;
						seen_d = status_q[2:0];
					end
					OFF_ODL:  rd = {PAD_ONES, latch_q};
					OFF_TMRH: begin
						rd       = count_q[15:8];
						blatch_d = count_q[7:0];
					end
					OFF_TMRL: rd = blatch_q;
					default: begin
						rd = UNDECODED;
						for (int j = 0; j < NUM_CHANNELS && j < NUM_FLAGS; j++) begin
							if (req.reg_offset == 4'(OFF_ODR0 + j)) begin
								rd = {PAD_ONES, odata_q[j]};
							end
							if (req.reg_offset == 4'(OFF_OCR0H + 2 * j)) begin
								rd = cmp_q[j][15:8];
							end
							if (req.reg_offset == 4'(OFF_OCR0L + 2 * j)) begin
								rd = cmp_q[j][7:0];
							end
						end
					end
				endcase
			end
			REQ_WRITE: begin
				unique case (req.reg_offset)
					OFF_TCR: begin
						ctrl_d  = req.write_data;
						presc_d = '0;
					end
					OFF_TMSR: begin
						// clear a flag only if it was seen set and 0 is written
						status_d = {req.write_data[7:3],
							status_q[2:0] & (req.write_data[2:0] | ~seen_q)};
						seen_d   = '0;
					end
					OFF_ODL:  latch_d  = req.write_data[5:0];
					OFF_TMRH: blatch_d = req.write_data;
					OFF_TMRL: count_d  = {blatch_q, req.write_data};
					default: begin
						for (int j = 0; j < NUM_FLAGS; j++) begin
							if (req.reg_offset == 4'(OFF_OCR0H + 2 * j)) begin
								blatch_d = req.write_data;
							end
						end
						for (int j = 0; j < NUM_CHANNELS && j < NUM_FLAGS; j++) begin
							if (req.reg_offset == 4'(OFF_ODR0 + j)) begin
								odata_d[j] = req.write_data[5:0];
							end
							if (req.reg_offset == 4'(OFF_OCR0L + 2 * j)) begin
								cmp_d[j] = {blatch_q, req.write_data};
							end
						end
					end
				endcase
			end
			default: ;
		endcase
	end

	always_comb begin
		irq = '0;
		for (int n = 0; n < NUM_CHANNELS && n < NUM_FLAGS; n++) begin
			irq[n] = status_d[n] && status_d[n + 3];
		end
		res.read_data      = rd;
		res.pin_levels     = latch_d;
		res.irq_lines      = irq;
		res.trigger_pulses = trig;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q   <= '0;
			status_q <= '0;
			latch_q  <= '0;
			count_q  <= '0;
			blatch_q <= '0;
			seen_q   <= '0;
			presc_q  <= '0;
			for (int j = 0; j < NUM_CHANNELS; j++) begin
				odata_q[j] <= '0;
				cmp_q[j]   <= CMP_RESET;
			end
		end else if (step) begin
			ctrl_q   <= ctrl_d;
			status_q <= status_d;
			latch_q  <= latch_d;
			count_q  <= count_d;
			blatch_q <= blatch_d;
			seen_q   <= seen_d;
			presc_q  <= presc_d;
			odata_q  <= odata_d;
			cmp_q    <= cmp_d;
		end
	end

endmodule

`default_nettype wire

// File: hdl/pct_checker.sv
// ---------------------------------------------------------------------------
// PWM compare timer checker
// Port-level assertions on the timer's stream behaviour.
// ---------------------------------------------------------------------------
`default_nettype none

`include "pwm_compare_timer_top_macros.svh"

module pct_checker import pct_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_axis_tvalid,
	input wire logic                   s_axis_tready,
	input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input wire logic [1:0]             s_axis_tuser,
	input wire logic                   m_axis_tvalid,
	input wire logic                   m_axis_tready,
	input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result holds
	`PCT_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	// an empty output register never blocks the input
	`PCT_ASSERT_NOW(a_in_free, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input blocked with output empty")

	// an accepted transaction reaches the output through the request and output registers when not stalled
	`PCT_ASSERT_NEXT(a_latency, clk, arst_n, (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready, m_axis_tvalid, "result missing after acceptance")

	// padding bits above the result fields stay clear
	`PCT_ASSERT_NOW(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[23:19] == 5'd0, "result padding not zero")

endmodule

bind pwm_compare_timer_top pct_checker u_pct_checker (.*);

`default_nettype wire
